[rtl/core/prar_pkg.sv]
// Shared types and constants for the polar ring artifact removal block.
package prar_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int TPL_W       = 17;
  localparam int COL_FIELD_W = 9;
  localparam int ROW_FIELD_W = 12;
  localparam int WIN_FIELD_W = 6;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 2;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW  = 2'd2;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_MEDIAN,
    PH_READ
  } phase_t;

  typedef enum logic [3:0] {
    MS_IDLE,
    MS_COL,
    MS_DEV,
    MS_DEVW,
    MS_DSTORE,
    MS_SEL,
    MS_SELW,
    MS_SELD,
    MS_DIV,
    MS_DIVW,
    MS_WR
  } med_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } med_status_t;

endpackage

[rtl/core/prar_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module prar_div #(
  parameter int DW = 22,
  parameter int WW = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic        [WW-1:0] divisor,
  output logic                 done,
  output logic signed [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [WW:0]     rem_r, rem_nxt;
  logic [DW-1:0]   quo_r, quo_nxt;
  logic            neg_r, neg_nxt;
  logic [WW:0]     rem_sh;
  logic            ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r[WW-1:0], quo_r[DW-1]};
    ge       = rem_sh >= {1'b0, divisor};
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = dividend[DW-1];
      quo_nxt  = dividend[DW-1] ? (-dividend) : dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNTW'(DW);
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

[rtl/core/prar_median.sv]
// Template engine: per-column deviations, bitwise median select, divide by window.
module prar_median #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 2048,
  parameter int MAX_WINDOW  = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]       col_count,
  input  logic [$clog2(MAX_ROWS+1)-1:0]          row_count,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]        win,
  output logic                                   img_re,
  output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0] img_addr,
  input  logic signed [prar_pkg::SAMPLE_W-1:0]   img_rdata,
  output logic                                   tpl_we,
  output logic [$clog2(MAX_COLUMNS)-1:0]         tpl_addr,
  output logic [prar_pkg::TPL_W-1:0]             tpl_wdata,
  output prar_pkg::med_status_t                  status
);

  import prar_pkg::*;

  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int CIW = $clog2(MAX_COLUMNS);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int WW  = $clog2(MAX_WINDOW + 1);
  localparam int AW  = $clog2(MAX_COLUMNS * MAX_ROWS);
  localparam int DW  = SAMPLE_W + 1 + $clog2(MAX_WINDOW);
  localparam int EW  = CW + WW + 1;
  localparam logic [DW-1:0] SIGN = {1'b1, {(DW-1){1'b0}}};

  med_state_t state_r, state_nxt;

  logic [CIW-1:0]       c_r, s_r;
  logic [RIW-1:0]       y_r;
  logic [WW-1:0]        k_r;
  logic [AW-1:0]        row_base_r;
  logic signed [DW-1:0] sum_r;
  logic signed [SAMPLE_W-1:0] ctr_r;
  logic                 rv_r, rctr_r;
  logic                 sv_r;
  logic [DW-1:0]        bit_r, mask_r, prefix_r;
  logic [RW-1:0]        rank_r, cnt0_r;
  logic [TPL_W-1:0]     tpl_val_r;

  logic [DW-1:0]        scr_mem [MAX_ROWS];
  logic [DW-1:0]        scr_rdata_r;
  logic                 scr_we, scr_re;

  logic                 elig, last_col, last_row, last_k, center;
  logic [EW-1:0]        s_calc;
  logic signed [WW+SAMPLE_W:0] prod;
  logic signed [DW-1:0] dev;
  logic [DW-1:0]        u;
  logic                 div_start, div_done;
  logic signed [DW-1:0] quotient;

  assign elig     = (EW'(c_r) + EW'(win)) < EW'(col_count);
  assign s_calc   = ((EW'(c_r) + EW'(1)) >= EW'(win)) ?
                    (EW'(c_r) + EW'(1) - EW'(win)) : '0;
  assign last_col = (CW'(c_r) + CW'(1)) == col_count;
  assign last_row = (RW'(y_r) + RW'(1)) == row_count;
  assign last_k   = (k_r + WW'(1)) == win;
  assign center   = (EW'(s_r) + EW'(k_r)) == EW'(c_r);
  assign prod     = $signed({1'b0, win}) * ctr_r;
  assign dev      = DW'(prod) - sum_r;
  assign u        = scr_rdata_r ^ SIGN;

  // next state and memory controls
  always_comb begin
    state_nxt = state_r;
    img_re    = 1'b0;
    scr_we    = 1'b0;
    scr_re    = 1'b0;
    tpl_we    = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      MS_IDLE:   if (start) state_nxt = MS_COL;
      MS_COL:    state_nxt = elig ? MS_DEV : MS_WR;
      MS_DEV: begin
        img_re = 1'b1;
        if (last_k) state_nxt = MS_DEVW;
      end
      MS_DEVW:   state_nxt = MS_DSTORE;
      MS_DSTORE: begin
        scr_we    = 1'b1;
        state_nxt = last_row ? MS_SEL : MS_DEV;
      end
      MS_SEL: begin
        scr_re = 1'b1;
        if (last_row) state_nxt = MS_SELW;
      end
      MS_SELW:   state_nxt = MS_SELD;
      MS_SELD:   state_nxt = bit_r[0] ? MS_DIV : MS_SEL;
      MS_DIV: begin
        div_start = 1'b1;
        state_nxt = MS_DIVW;
      end
      MS_DIVW:   if (div_done) state_nxt = MS_WR;
      MS_WR: begin
        tpl_we    = 1'b1;
        state_nxt = last_col ? MS_IDLE : MS_COL;
      end
      default:   state_nxt = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
      rv_r    <= 1'b0;
      sv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= img_re;
      sv_r    <= scr_re;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rctr_r <= center;
    if (rv_r) begin
      sum_r <= sum_r + {{(DW-SAMPLE_W){img_rdata[SAMPLE_W-1]}}, img_rdata};
      if (rctr_r) ctr_r <= img_rdata;
    end
    if (sv_r && (((u ^ prefix_r) & mask_r) == '0) && ((u & bit_r) == '0)) begin
      cnt0_r <= cnt0_r + RW'(1);
    end
    case (state_r)
      MS_IDLE: c_r <= '0;
      MS_COL: begin
        s_r        <= CIW'(s_calc);
        y_r        <= '0;
        k_r        <= '0;
        row_base_r <= '0;
        sum_r      <= '0;
        tpl_val_r  <= '0;
      end
      MS_DEV: k_r <= k_r + WW'(1);
      MS_DSTORE: begin
        k_r   <= '0;
        sum_r <= '0;
        if (last_row) begin
          y_r      <= '0;
          bit_r    <= SIGN;
          mask_r   <= '0;
          prefix_r <= '0;
          rank_r   <= row_count >> 1;
          cnt0_r   <= '0;
        end else begin
          y_r        <= y_r + RIW'(1);
          row_base_r <= row_base_r + AW'(col_count);
        end
      end
      MS_SEL: y_r <= y_r + RIW'(1);
      MS_SELD: begin
        if (rank_r >= cnt0_r) begin
          prefix_r <= prefix_r | bit_r;
          rank_r   <= rank_r - cnt0_r;
        end
        mask_r <= mask_r | bit_r;
        bit_r  <= bit_r >> 1;
        cnt0_r <= '0;
        y_r    <= '0;
      end
      MS_DIVW: if (div_done) tpl_val_r <= quotient[TPL_W-1:0];
      MS_WR:   c_r <= c_r + CIW'(1);
      default: ;
    endcase
  end

  // deviation scratch, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[y_r] <= dev;
    if (scr_re) scr_rdata_r <= scr_mem[y_r];
  end

  prar_div #(.DW(DW), .WW(WW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ($signed(prefix_r ^ SIGN)),
    .divisor  (win),
    .done     (div_done),
    .quotient (quotient)
  );

  assign img_addr    = row_base_r + AW'(s_r) + AW'(k_r);
  assign tpl_addr    = c_r;
  assign tpl_wdata   = tpl_val_r;
  assign status.busy = (state_r != MS_IDLE);
  assign status.done = (state_r == MS_WR) && last_col;

endmodule

[rtl/core/polar_ring_artifact_removal_top.sv]
// Top level: image store, template store, load and read-out control.
//
//  channel | dir | signals                          | transfer when
//  in      | in  | in_tvalid/tready, tdata, tuser   | in_tvalid & in_tready
//  out     | out | out_tvalid/tready, tdata, tlast  | out_tvalid & out_tready
//  cfg     | in  | cfg_valid/ready, index, data     | cfg_valid & cfg_ready
//
// Loads are always accepted in the load phase and written through the image memory
// write port; a read-out request reads the image and template stores into the read
// stage, then its result is registered in the output register while a new request can enter.
// The load that completes the image starts the template pass; in_tready and
// cfg_ready stay low until the pass is done, its pace set by the image and
// scratch memory ports (one access each per cycle).
// Reset is synchronous; no clearing pass (template store has per-entry valid bits).
// A stalled output holds; one further request can sit in the read stage.
module polar_ring_artifact_removal_top #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 2048,
  parameter int MAX_WINDOW  = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // [15:0] sample
  input  logic                               in_tuser,   // [0] command
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // [15:0] corrected
  output logic                               out_tlast,  // last_sample
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [prar_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [prar_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import prar_pkg::*;

  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int CIW   = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int WW    = $clog2(MAX_WINDOW + 1);
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int COL_RST = (230 > MAX_COLUMNS) ? MAX_COLUMNS : 230;
  localparam int ROW_RST = (1446 > MAX_ROWS) ? MAX_ROWS : 1446;
  localparam int WIN_RST = (9 > MAX_WINDOW) ? MAX_WINDOW : 9;

  phase_t          phase_r;
  logic [CW-1:0]   col_r;
  logic [RW-1:0]   row_r;
  logic [WW-1:0]   win_r;
  logic [AW-1:0]   load_pos_r, read_pos_r;
  logic [CIW-1:0]  rcol_r;
  logic            med_go_r;
  logic            pend_r, pend_last_r;
  logic            out_valid_r;
  logic [15:0]     out_data_r;
  logic            out_last_r;

  logic [15:0]          img_mem [DEPTH];
  logic signed [15:0]   img_rdata_r;
  logic [TPL_W-1:0]     tpl_mem [MAX_COLUMNS];
  logic [TPL_W-1:0]     tpl_rdata_r;
  logic [MAX_COLUMNS-1:0] tpl_vld_r;
  logic                 tpl_rvld_r;

  logic                 in_acc, cfg_acc, load_acc, req_acc, move;
  logic [AW:0]          total;
  logic                 load_done, read_last, rcol_last;
  logic                 med_start;
  logic                 med_re, med_tpl_we;
  logic [AW-1:0]        med_addr, img_raddr;
  logic [CIW-1:0]       med_tpl_addr;
  logic [TPL_W-1:0]     med_tpl_wdata;
  med_status_t          med_status;
  logic [COL_FIELD_W-1:0] cfg_col;
  logic [ROW_FIELD_W-1:0] cfg_row;
  logic [WIN_FIELD_W-1:0] cfg_win;
  logic signed [TPL_W-1:0] tpl_eff, diff;

  // handshakes
  assign move      = pend_r && (!out_valid_r || out_tready);
  assign in_tready = (phase_r == PH_LOAD) || ((phase_r == PH_READ) && (!pend_r || move));
  assign cfg_ready = (phase_r != PH_MEDIAN);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign load_acc  = in_acc && (in_tuser == CMD_LOAD) && (phase_r == PH_LOAD);
  assign req_acc   = in_acc && (in_tuser == CMD_REQUEST) && (phase_r == PH_READ);

  assign total     = (AW+1)'(col_r * row_r);
  assign load_done = ((AW+1)'(load_pos_r) + (AW+1)'(1)) >= total;
  assign read_last = ((AW+1)'(read_pos_r) + (AW+1)'(1)) >= total;
  assign rcol_last = (CW'(rcol_r) + CW'(1)) == col_r;
  // template pass waits until any in-flight read-out has left the read stage
  assign med_start = (phase_r == PH_MEDIAN) && !med_go_r && !pend_r;

  assign cfg_col = cfg_data[COL_FIELD_W-1:0];
  assign cfg_row = cfg_data[ROW_FIELD_W-1:0];
  assign cfg_win = cfg_data[WIN_FIELD_W-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LOAD;
      col_r       <= CW'(COL_RST);
      row_r       <= RW'(ROW_RST);
      win_r       <= WW'(WIN_RST);
      load_pos_r  <= '0;
      read_pos_r  <= '0;
      rcol_r      <= '0;
      med_go_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_acc && (cfg_index == REG_COLUMNS || cfg_index == REG_ROWS ||
                      cfg_index == REG_WINDOW)) begin
        unique case (cfg_index)
          REG_COLUMNS: col_r <= (cfg_col < COL_FIELD_W'(2)) ? CW'(2) :
                                (int'(cfg_col) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(cfg_col);
          REG_ROWS:    row_r <= (cfg_row == '0) ? RW'(1) :
                                (int'(cfg_row) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(cfg_row);
          REG_WINDOW:  win_r <= (cfg_win == '0) ? WW'(1) :
                                (int'(cfg_win) > MAX_WINDOW) ? WW'(MAX_WINDOW) : WW'(cfg_win);
          default:     ;
        endcase
        phase_r    <= PH_LOAD;
        load_pos_r <= '0;
        read_pos_r <= '0;
        rcol_r     <= '0;
      end else begin
        if (load_acc) begin
          if (load_done) begin
            phase_r    <= PH_MEDIAN;
            load_pos_r <= '0;
          end else begin
            load_pos_r <= load_pos_r + AW'(1);
          end
        end
        if (med_start) med_go_r <= 1'b1;
        if (med_status.done) begin
          med_go_r   <= 1'b0;
          phase_r    <= PH_READ;
          read_pos_r <= '0;
          rcol_r     <= '0;
        end
        if (req_acc) begin
          if (read_last) begin
            phase_r    <= PH_LOAD;
            read_pos_r <= '0;
            rcol_r     <= '0;
          end else begin
            read_pos_r <= read_pos_r + AW'(1);
            rcol_r     <= rcol_last ? '0 : rcol_r + CIW'(1);
          end
        end
      end
      if (req_acc)   pend_r <= 1'b1;
      else if (move) pend_r <= 1'b0;
      if (move)            out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // read stage and output register payload
  assign tpl_eff = tpl_rvld_r ? $signed(tpl_rdata_r) : '0;
  assign diff    = {img_rdata_r[15], img_rdata_r} - tpl_eff;

  always_ff @(posedge clk) begin
    if (req_acc) pend_last_r <= read_last;
    if (move) begin
      out_data_r <= diff[15:0];
      out_last_r <= pend_last_r;
    end
  end

  // image store: one write (load) and one read (template pass or read-out) a cycle;
  // phases never overlap, so no forwarding is needed
  assign img_raddr = (phase_r == PH_MEDIAN) ? med_addr : read_pos_r;

  always_ff @(posedge clk) begin
    if (load_acc) img_mem[load_pos_r] <= in_tdata;
    if (med_re || req_acc) img_rdata_r <= img_mem[img_raddr];
  end

  // template store with per-entry valid bits (reads as zero until written)
  always_ff @(posedge clk) begin
    if (med_tpl_we) tpl_mem[med_tpl_addr] <= med_tpl_wdata;
    if (req_acc) begin
      tpl_rdata_r <= tpl_mem[rcol_r];
      tpl_rvld_r  <= tpl_vld_r[rcol_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpl_vld_r <= '0;
    end else if (med_tpl_we) begin
      tpl_vld_r[med_tpl_addr] <= 1'b1;
    end
  end

  prar_median #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (med_start),
    .col_count (col_r),
    .row_count (row_r),
    .win       (win_r),
    .img_re    (med_re),
    .img_addr  (med_addr),
    .img_rdata (img_rdata_r),
    .tpl_we    (med_tpl_we),
    .tpl_addr  (med_tpl_addr),
    .tpl_wdata (med_tpl_wdata),
    .status    (med_status)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/core/prar_checker.sv]
// Port-level checks for the top level, attached by bind.
module prar_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  import prar_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input closed with nothing to deliver only during the template pass
  a_busy_blocks_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && !out_tvalid |-> !cfg_ready)
    else $error("config open while template pass runs");

  // a new result follows a request transfer, through the read stage and output register
  a_rise_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && (in_tuser == CMD_REQUEST), 2))
    else $error("result without request");

endmodule

bind polar_ring_artifact_removal_top prar_checker u_prar_checker (.*);

[verif/polar_ring_artifact_removal_top_test.sv]
// Testbench for the polar ring artifact removal block: image loads, template pass, read-out.
`timescale 1ns / 100ps

module polar_ring_artifact_removal_top_test;
  import prar_pkg::*;

  localparam int NCOL = 256;
  localparam int NROW = 2048;
  localparam int NWIN = 32;
  localparam int STORE = NCOL * NROW;
  // no transfer at all for this long means the block hung; the limit lies
  // above the longest template pass used here (20 x 60 random image)
  localparam int STALL_LIMIT = 600000;

  typedef struct packed {
    logic [15:0] corrected;
    logic        last;
  } pixel_out_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [15:0] sample
  logic        in_tuser;    // [0] command
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [15:0] corrected
  logic        out_tlast;   // last_sample
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  polar_ring_artifact_removal_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------- predictor state
  logic signed [15:0] pix_mem [0:STORE-1];
  int                 col_tpl [0:NCOL-1];
  int                 dev_buf [0:NROW-1];
  int                 cols_cfg, rows_cfg, win_cfg;
  int                 load_pos, read_pos;
  bit                 reading;

  pixel_out_t pending_pixels[$];

  int  n_errors;
  int  n_loads, n_requests, n_results, n_ignored, n_cfg, n_images;
  bit  no_idle;    // long stretch with both sides busy
  bit  hold_req;   // ask the receiver for a long hold-off
  int  stall_cnt;

  // ---------------------------------------------------------------- clock, reset
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_image();
    load_pos = 0;
    read_pos = 0;
    reading  = 1'b0;
  endfunction

  function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_COLUMNS: cols_cfg = clamp(int'(val[8:0]), 2, NCOL);
      REG_ROWS:    rows_cfg = clamp(int'(val[11:0]), 1, NROW);
      REG_WINDOW:  win_cfg  = clamp(int'(val[5:0]), 1, NWIN);
      default:     return;  // unknown index: no effect, image kept
    endcase
    restart_image();
  endfunction

  // upper median of the per-row deviations, divided by the window width
  function automatic void compute_templates();
    int s, sum, key, j;
    for (int c = 0; c < cols_cfg; c++) begin
      if (c + win_cfg < cols_cfg) begin
        s = (c + 1 >= win_cfg) ? c + 1 - win_cfg : 0;
        for (int y = 0; y < rows_cfg; y++) begin
          sum = 0;
          for (int k = 0; k < win_cfg; k++) sum += int'(pix_mem[y * cols_cfg + s + k]);
          dev_buf[y] = win_cfg * int'(pix_mem[y * cols_cfg + c]) - sum;
        end
        for (int i = 1; i < rows_cfg; i++) begin
          key = dev_buf[i];
          j = i - 1;
          while (j >= 0 && dev_buf[j] > key) begin
            dev_buf[j + 1] = dev_buf[j];
            j--;
          end
          dev_buf[j + 1] = key;
        end
        col_tpl[c] = dev_buf[rows_cfg / 2] / win_cfg;  // truncates toward zero
      end else begin
        col_tpl[c] = 0;
      end
    end
  endfunction

  function automatic void predict_transfer(logic cmd, logic [15:0] smp);
    int total, v;
    pixel_out_t p;
    total = cols_cfg * rows_cfg;
    if (cmd == CMD_LOAD) begin
      if (reading) begin
        n_ignored++;
        return;
      end
      pix_mem[load_pos] = smp;
      load_pos++;
      n_loads++;
      if (load_pos >= total) begin
        compute_templates();
        reading  = 1'b1;
        read_pos = 0;
      end
    end else begin
      if (!reading) begin
        n_ignored++;
        return;
      end
      v = int'(pix_mem[read_pos]) - col_tpl[read_pos % cols_cfg];
      p.corrected = v[15:0];
      p.last = (read_pos + 1 >= total);
      pending_pixels.push_back(p);
      n_requests++;
      if (p.last) begin
        restart_image();
        n_images++;
      end else begin
        read_pos++;
      end
    end
  endfunction

  // ---------------------------------------------------------------- result checker
  always @(posedge clk) begin
    pixel_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_pixels.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result corrected=%h last=%b", $time, out_tdata, out_tlast);
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata !== want.corrected) begin
          n_errors++;
          $display("%0t: corrected expected %h actual %h", $time, want.corrected, out_tdata);
        end
        if (out_tlast !== want.last) begin
          n_errors++;
          $display("%0t: last_sample expected %b actual %b", $time, want.last, out_tlast);
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off so the read stage fills and in_tready drops
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= 31);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_item(logic cmd, logic [15:0] smp);
    if (!no_idle) begin
      while ($urandom_range(99) < 31) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    predict_transfer(cmd, smp);
  endtask

  // drain all results, then give a trailing request time to settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, val);
    n_cfg++;
  endtask

  task automatic set_shape(int c, int r, int w);
    write_register(REG_COLUMNS, CFG_DATA_W'(c));
    write_register(REG_ROWS, CFG_DATA_W'(r));
    write_register(REG_WINDOW, CFG_DATA_W'(w));
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // one full image: loads, then read-out; noise_pct adds ignored transfers
  task automatic run_image(int noise_pct);
    int total;
    total = cols_cfg * rows_cfg;
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(CMD_REQUEST, 16'($urandom));
      send_item(CMD_LOAD, pick_sample());
    end
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(CMD_LOAD, 16'($urandom));
      send_item(CMD_REQUEST, 16'($urandom));
    end
  endtask

  // ---------------------------------------------------------------- tests
  // out-of-range values saturate, unknown index ignored, sign extremes
  task automatic test_register_limits();
    write_register(REG_COLUMNS, 12'h000);
    write_register(REG_ROWS, 12'h000);
    write_register(REG_WINDOW, 12'h000);
    write_register(2'd3, 12'hfff);
    // request while loading is ignored
    send_item(CMD_REQUEST, 16'h0000);
    send_item(CMD_LOAD, 16'h8000);
    send_item(CMD_LOAD, 16'h7fff);
    // load while reading is ignored
    send_item(CMD_LOAD, 16'hffff);
    send_item(CMD_REQUEST, 16'hffff);
    send_item(CMD_REQUEST, 16'h0000);
  endtask

  // window at least as wide as the image: no column corrected
  task automatic test_wide_window();
    set_shape(4, 3, 12'h03f);
    run_image(0);
  endtask

  // widest image: 9-bit field all ones saturates to 256 columns
  task automatic test_max_columns();
    set_shape(12'h3ff, 1, 7);
    run_image(0);
    set_shape(40, 3, 31);
    run_image(0);
  endtask

  // row field all ones saturates; the partial tall image is dropped,
  // then a tall image with the narrowest window
  task automatic test_max_rows();
    set_shape(2, 12'hfff, 1);
    for (int i = 0; i < 40; i++) send_item(CMD_LOAD, pick_sample());
    send_item(CMD_REQUEST, 16'h0000);
    write_register(REG_ROWS, 12'd60);
    run_image(0);
  endtask

  // a register write in the middle of a load drops the partial image
  task automatic test_abort();
    set_shape(6, 3, 2);
    for (int i = 0; i < 7; i++) send_item(CMD_LOAD, pick_sample());
    write_register(REG_WINDOW, 12'd3);
    run_image(0);
    // and one in the middle of a read-out
    for (int i = 0; i < 18; i++) send_item(CMD_LOAD, pick_sample());
    for (int i = 0; i < 5; i++) send_item(CMD_REQUEST, 16'h0000);
    write_register(REG_ROWS, 12'd2);
    run_image(0);
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    set_shape(16, 4, 5);
    for (int i = 0; i < 64; i++) send_item(CMD_LOAD, pick_sample());
    wait_drained();
    hold_req = 1'b1;
    for (int i = 0; i < 64; i++) send_item(CMD_REQUEST, 16'h0000);
  endtask

  task automatic test_random_images();
    int c, r;
    while (n_loads + n_requests < 1300) begin
      c = $urandom_range(2, 20);
      r = $urandom_range(1, 8);
      if ($urandom_range(9) == 0) r = $urandom_range(30, 60);
      set_shape(c, r, $urandom_range(1, c + 2));
      no_idle = ($urandom_range(5) == 0);
      run_image($urandom_range(9) < 8 ? 4 : 25);
      no_idle = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_LOAD;
    cfg_valid = 1'b0;
    cfg_index = REG_COLUMNS;
    cfg_data = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    n_errors = 0;
    n_loads = 0; n_requests = 0; n_results = 0; n_ignored = 0; n_cfg = 0; n_images = 0;
    for (int i = 0; i < NCOL; i++) col_tpl[i] = 0;
    cols_cfg = 230; rows_cfg = 1446; win_cfg = 9;
    restart_image();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_limits();
    test_wide_window();
    test_max_columns();
    test_max_rows();
    test_abort();
    test_backpressure();
    test_random_images();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d loads, %0d read-outs, %0d ignored transfers, %0d images,",
             n_loads, n_requests, n_ignored, n_images);
    $display("%0d register writes incl. saturation, aborts and output hold-off", n_cfg);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
